// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int PIN_W     = 6;
    localparam int THR_W     = 16;
    localparam int IDX_W     = 2;
    localparam int COUNT_W   = 3;

    // A millisecond count derived from a 32-bit microsecond tick stays below 2^23.
    localparam int NOW_W = 23;

    // x / 1000 == (x * 0x10624DD3) >> 38 for every 32-bit x.
    localparam logic [31:0] MS_RECIP = 32'h10624DD3;
    localparam int          MS_SHIFT = 38;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_BUTTON_PINS    = 3'd0;
    localparam logic [2:0] REG_BUTTON_COUNT   = 3'd1;
    localparam logic [2:0] REG_PRESSED_LEVELS = 3'd2;
    localparam logic [2:0] REG_LONG_MS_0      = 3'd3;
    localparam logic [2:0] REG_LONG_MS_1      = 3'd4;
    localparam logic [2:0] REG_LONG_MS_2      = 3'd5;
    localparam logic [2:0] REG_LONG_MS_3      = 3'd6;

    localparam logic [THR_W-1:0] LONG_MS_RESET = 16'd1000;

    typedef struct packed {
        logic [NUM_SLOTS*PIN_W-1:0]          pins;
        logic [COUNT_W-1:0]                  count;
        logic [NUM_SLOTS-1:0]                levels;
        logic [NUM_SLOTS-1:0][THR_W-1:0]     long_ms;
    } t_cfg;

    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic             level;
        logic [NOW_W-1:0] now;
    } t_job;

endpackage

// ===== hw/rtl/bpc_cfg.sv =====
module bpc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
    output logic [bpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output bpc_pkg::t_cfg               o_cfg
);
    import bpc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pins    <= '0;
            r_cfg.count   <= '0;
            r_cfg.levels  <= '0;
            r_cfg.long_ms <= {NUM_SLOTS{LONG_MS_RESET}};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BUTTON_PINS:    r_cfg.pins    <= pwdata[NUM_SLOTS*PIN_W-1:0];
                REG_BUTTON_COUNT:   r_cfg.count   <= pwdata[COUNT_W-1:0];
                REG_PRESSED_LEVELS: r_cfg.levels  <= pwdata[NUM_SLOTS-1:0];
                REG_LONG_MS_0:      r_cfg.long_ms[0] <= pwdata[THR_W-1:0];
                REG_LONG_MS_1:      r_cfg.long_ms[1] <= pwdata[THR_W-1:0];
                REG_LONG_MS_2:      r_cfg.long_ms[2] <= pwdata[THR_W-1:0];
                REG_LONG_MS_3:      r_cfg.long_ms[3] <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BUTTON_PINS:    prdata = DATA_W'(r_cfg.pins);
            REG_BUTTON_COUNT:   prdata = DATA_W'(r_cfg.count);
            REG_PRESSED_LEVELS: prdata = DATA_W'(r_cfg.levels);
            REG_LONG_MS_0:      prdata = DATA_W'(r_cfg.long_ms[0]);
            REG_LONG_MS_1:      prdata = DATA_W'(r_cfg.long_ms[1]);
            REG_LONG_MS_2:      prdata = DATA_W'(r_cfg.long_ms[2]);
            REG_LONG_MS_3:      prdata = DATA_W'(r_cfg.long_ms[3]);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/bpc_front.sv =====
module bpc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bpc_pkg::PIN_W-1:0]   i_pin_number,
    input  logic [1:0]                  i_pin_level,
    input  logic [31:0]                 i_tick_us,
    output logic                        o_push,
    output bpc_pkg::t_job               o_job,
    input  logic                        i_q_full
);
    import bpc_pkg::*;

    logic        r_valid, n_valid;
    t_job        r_job;
    logic [63:0] prod;
    logic        accept;
    logic        load;

    assign prod    = 64'(i_tick_us) * 64'(MS_RECIP);
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    // Timeout levels are taken and dropped here.
    assign load    = accept && !i_pin_level[1];
    assign o_push  = r_valid && !i_q_full;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job.pin   <= i_pin_number;
            r_job.level <= i_pin_level[0];
            r_job.now   <= prod[MS_SHIFT +: NOW_W];
        end
    end

endmodule

// ===== hw/rtl/bpc_queue.sv =====
module bpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bpc_pkg::t_job o_job
);
    import bpc_pkg::*;

    t_job [1:0] r_mem;
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/bpc_back.sv =====
module bpc_back #(
    parameter int NUM_BUTTONS = 4,
    parameter int DEBOUNCE_MS = 50
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpc_pkg::t_cfg               i_cfg,
    input  logic                        i_q_valid,
    input  bpc_pkg::t_job               i_q_job,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bpc_pkg::IDX_W-1:0]   o_button_index,
    output logic                        o_is_long,
    output logic                        o_last_of_run
);
    import bpc_pkg::*;

    localparam int CAP_INT = (NUM_BUTTONS < NUM_SLOTS) ? NUM_BUTTONS : NUM_SLOTS;
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);
    localparam logic [NOW_W-1:0]   DEB = NOW_W'(DEBOUNCE_MS);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(NUM_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [IDX_W-1:0]                r_idx, n_idx;
    t_job                            r_job;
    logic [NUM_SLOTS-1:0][NOW_W-1:0] r_start, n_start;
    logic                            r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]                r_pend_idx, n_pend_idx;
    logic                            r_pend_long, n_pend_long;
    logic                            r_o_valid, n_o_valid;
    logic [IDX_W-1:0]                r_o_idx, n_o_idx;
    logic                            r_o_long, n_o_long;
    logic                            r_o_last, n_o_last;

    logic [COUNT_W-1:0] n_active;
    logic               enabled;
    logic [PIN_W-1:0]   bpin;
    logic [NOW_W-1:0]   start;
    logic               held;
    logic               match;
    logic               rec;
    logic               clr;
    logic [NOW_W:0]     diff;
    logic               res;
    logic               is_long;
    logic               out_free;
    logic               blocked;

    assign n_active = (i_cfg.count > CAP) ? CAP : i_cfg.count;
    assign enabled  = ({1'b0, r_idx} < n_active);
    assign bpin     = i_cfg.pins[PIN_W*r_idx +: PIN_W];
    assign start    = r_start[r_idx];
    assign held     = (start != '0);
    assign match    = enabled && (bpin == r_job.pin);
    assign rec      = match && (r_job.level == i_cfg.levels[r_idx]) && !held;
    assign clr      = match && !rec && held;
    // A wrapped (negative) elapsed time shows up as the borrow bit.
    assign diff     = {1'b0, r_job.now} - {1'b0, start};
    assign res      = clr && !diff[NOW_W] && (diff[NOW_W-1:0] >= DEB);
    assign is_long  = (diff[NOW_W-1:0] > NOW_W'(i_cfg.long_ms[r_idx]));
    assign out_free = !r_o_valid || !i_stall;
    assign blocked  = res && r_pend_valid && !out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;

    assign o_valid        = r_o_valid;
    assign o_button_index = r_o_idx;
    assign o_is_long      = r_o_long;
    assign o_last_of_run  = r_o_last;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_start      = r_start;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_long  = r_pend_long;
        n_o_valid    = r_o_valid && i_stall;
        n_o_idx      = r_o_idx;
        n_o_long     = r_o_long;
        n_o_last     = r_o_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_idx   = '0;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!blocked) begin
                    if (rec) begin
                        n_start[r_idx] = r_job.now;
                    end else if (clr) begin
                        n_start[r_idx] = '0;
                    end
                    if (res) begin
                        // A newer result means the held one is not the last of the run.
                        if (r_pend_valid) begin
                            n_o_valid = 1'b1;
                            n_o_idx   = r_pend_idx;
                            n_o_long  = r_pend_long;
                            n_o_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_idx;
                        n_pend_long  = is_long;
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = (r_pend_valid || res) ? ST_FLUSH : ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_idx      = r_pend_idx;
                    n_o_long     = r_pend_long;
                    n_o_last     = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_start      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_start      <= n_start;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        r_pend_idx  <= n_pend_idx;
        r_pend_long <= n_pend_long;
        r_o_idx     <= n_o_idx;
        r_o_long    <= n_o_long;
        r_o_last    <= n_o_last;
    end

endmodule

// ===== hw/rtl/button_press_classifier_core.sv =====
// Short/long press classifier for up to four buttons. Each input beat is one pin
// edge (pin, level, microsecond tick); levels 2 and 3 are accepted and dropped.
// The front end converts the tick to milliseconds with a registered reciprocal
// multiply and hands the event to a two-entry queue. The back end walks the four
// button slots one per cycle unless a stalled output holds the walk, updating each
// slot's press start and producing at most one result per slot; the final result
// of an event carries o_last_of_run. Each event passes through a pop state, a walk
// over the slots and, when it produced a result, a flush state; the back end pops
// the next event only once it is back in idle. Results wait in a pending register
// and a single output register, and a stalled output only holds the walk when a
// second result must be handed on.
// Registers sit at byte addresses 4*i on the APB port; no clearing pass follows
// reset.
module button_press_classifier_core #(
    parameter int NUM_BUTTONS = 4,
    parameter int DEBOUNCE_MS = 50
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bpc_pkg::PIN_W-1:0]   i_pin_number,
    input  logic [1:0]                  i_pin_level,
    input  logic [31:0]                 i_tick_us,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bpc_pkg::IDX_W-1:0]   o_button_index,
    output logic                        o_is_long,
    output logic                        o_last_of_run,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
    output logic [bpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bpc_pkg::*;

    t_cfg cfg;
    t_job front_job;
    t_job q_job;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    bpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pin_number (i_pin_number),
        .i_pin_level  (i_pin_level),
        .i_tick_us    (i_tick_us),
        .o_push       (front_push),
        .o_job        (front_job),
        .i_q_full     (q_full)
    );

    bpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    bpc_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .DEBOUNCE_MS (DEBOUNCE_MS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_button_index (o_button_index),
        .o_is_long      (o_is_long),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ===== hw/rtl/bpc_checker.sv =====
module bpc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [bpc_pkg::IDX_W-1:0]   o_button_index,
    input logic                        o_is_long,
    input logic                        o_last_of_run,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input logic [bpc_pkg::DATA_W-1:0]  pwdata,
    input logic [bpc_pkg::DATA_W-1:0]  prdata,
    input logic                        pready
);
    import bpc_pkg::*;

    // A result beat held by the consumer keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_button_index)
            && $stable(o_is_long) && $stable(o_last_of_run))
        else $error("result beat changed while stalled");

    // No result may be pending right after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // Reading the button count right after writing it returns the written value.
    a_count_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && psel && !pwrite
            && $past(psel && penable && pwrite && pready)
            && paddr == $past(paddr) && paddr[4:2] == REG_BUTTON_COUNT
            |-> prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))
        else $error("button count readback mismatch");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_button_index (o_button_index),
    .o_is_long      (o_is_long),
    .o_last_of_run  (o_last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bpc_pkg::*;

    localparam int NUM_BUTTONS = 4;
    localparam int DEBOUNCE    = 50;
    localparam int QUIET_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 49;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             is_long;
        logic             last;
    } t_press;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [PIN_W-1:0]    i_pin_number = '0;
    logic [1:0]          i_pin_level = '0;
    logic [31:0]         i_tick_us = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [IDX_W-1:0]    o_button_index;
    logic                o_is_long;
    logic                o_last_of_run;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predictor state: a copy of the registers and of each button's press start.
    t_cfg        model_cfg;
    logic [31:0] press_start[NUM_SLOTS];
    t_press      pending_presses[$];

    t_idle_mode  idle_mode = IDLE_NONE;
    logic [31:0] cur_tick;
    int          mismatches = 0;
    int          events_sent = 0;
    int          results_checked = 0;
    int          cycle_count = 0;

    button_press_classifier_core #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .DEBOUNCE_MS(DEBOUNCE)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_pin_number(i_pin_number),
        .i_pin_level(i_pin_level),
        .i_tick_us(i_tick_us),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_button_index(o_button_index),
        .o_is_long(o_is_long),
        .o_last_of_run(o_last_of_run),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still expected",
                 CYCLE_LIMIT, pending_presses.size());
        $display("testbench: done, errors");
        $finish;
    end

    function automatic int sender_idle_pct();
        return (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (idle_mode == IDLE_RECEIVER) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    endfunction

    function automatic void reset_model();
        model_cfg.pins = '0;
        model_cfg.count = '0;
        model_cfg.levels = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            model_cfg.long_ms[i] = LONG_MS_RESET;
            press_start[i] = '0;
        end
    endfunction

    // Walks the enabled buttons in index order and queues the presses this edge completes.
    function automatic void classify_edge(logic [PIN_W-1:0] pin, logic [1:0] level,
                                          logic [31:0] tick);
        logic [31:0] now;
        logic [31:0] elapsed;
        int          active;
        t_press      hits[$];
        t_press      r;
        if (level > 2'd1) return;
        now = tick / 1000;
        active = (model_cfg.count > NUM_SLOTS) ? NUM_SLOTS : model_cfg.count;
        if (active > NUM_BUTTONS) active = NUM_BUTTONS;
        for (int i = 0; i < active; i++) begin
            if (model_cfg.pins[PIN_W*i +: PIN_W] != pin) continue;
            if (level[0] == model_cfg.levels[i] && press_start[i] == 0) begin
                press_start[i] = now;
            end else if (press_start[i] != 0) begin
                elapsed = now - press_start[i];
                press_start[i] = '0;
                // A wrapped (negative) elapsed time counts as a bounce.
                if (!elapsed[31] && elapsed >= DEBOUNCE) begin
                    r.idx = IDX_W'(i);
                    r.is_long = elapsed > 32'(model_cfg.long_ms[i]);
                    r.last = 1'b0;
                    hits.push_back(r);
                end
            end
        end
        if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
        foreach (hits[k]) pending_presses.push_back(hits[k]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Result side: random stall and comparison of every accepted beat.
    always @(posedge i_clk) begin
        t_press expd;
        cycle_count <= cycle_count + 1;
        i_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_presses.size() == 0) begin
                report_mismatch($sformatf("unexpected result button %0d long %0d last %0d",
                                          o_button_index, o_is_long, o_last_of_run));
            end else begin
                expd = pending_presses.pop_front();
                results_checked++;
                if (o_button_index !== expd.idx)
                    report_mismatch($sformatf("button_index %0d, expected %0d",
                                              o_button_index, expd.idx));
                if (o_is_long !== expd.is_long)
                    report_mismatch($sformatf("is_long %0d, expected %0d",
                                              o_is_long, expd.is_long));
                if (o_last_of_run !== expd.last)
                    report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                              o_last_of_run, expd.last));
            end
        end
    end

    task automatic send_event(input logic [PIN_W-1:0] pin, input logic [1:0] level,
                              input logic [31:0] tick);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < sender_idle_pct()) gap++;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_pin_number <= pin;
            i_pin_level <= level;
            i_tick_us <= tick;
            do @(posedge i_clk); while (o_stall);
            classify_edge(pin, level, tick);
            events_sent++;
        end
    endtask

    // Drops valid and waits until every expected press is out and the block has
    // had time to finish events that produce nothing.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_presses.size() != 0) @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    task automatic config_write(input logic [2:0] reg_idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({reg_idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_idx)
            REG_BUTTON_PINS:    model_cfg.pins = value[NUM_SLOTS*PIN_W-1:0];
            REG_BUTTON_COUNT:   model_cfg.count = value[COUNT_W-1:0];
            REG_PRESSED_LEVELS: model_cfg.levels = value[NUM_SLOTS-1:0];
            REG_LONG_MS_0, REG_LONG_MS_1, REG_LONG_MS_2, REG_LONG_MS_3:
                model_cfg.long_ms[IDX_W'(reg_idx - REG_LONG_MS_0)] = value[THR_W-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all registers; the unused upper bits carry junk that must be dropped.
    task automatic apply_config(input t_cfg c);
        logic [31:0] junk;
        begin
            junk = $urandom;
            config_write(REG_BUTTON_PINS, {junk[31:24], c.pins});
            config_write(REG_BUTTON_COUNT, {junk[31:3], c.count});
            config_write(REG_PRESSED_LEVELS, {junk[31:4], c.levels});
            for (int i = 0; i < NUM_SLOTS; i++)
                config_write(3'(REG_LONG_MS_0 + i), {junk[31:16], c.long_ms[i]});
        end
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        int   mode;
        logic [PIN_W-1:0] p0, p1;
        mode = $urandom_range(0, 2);
        p0 = PIN_W'($urandom);
        p1 = PIN_W'($urandom);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (mode == 0)      c.pins[PIN_W*i +: PIN_W] = PIN_W'($urandom);
            else if (mode == 1) c.pins[PIN_W*i +: PIN_W] = $urandom_range(0, 1) ? p0 : p1;
            else                c.pins[PIN_W*i +: PIN_W] = p0;
            case ($urandom_range(0, 9))
                0:       c.long_ms[i] = '0;
                1:       c.long_ms[i] = '1;
                default: c.long_ms[i] = THR_W'($urandom_range(50, 2500));
            endcase
        end
        c.count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 7))
                                               : COUNT_W'($urandom_range(1, 4));
        c.levels = NUM_SLOTS'($urandom);
        return c;
    endfunction

    // Hold times cluster around the debounce limit and the long-press threshold.
    function automatic int pick_hold(logic [THR_W-1:0] thr);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 49);
            2:       return $urandom_range(49, 51);
            3, 4:    return int'(thr) + int'($urandom_range(0, 2)) - 1;
            9:       return $urandom_range(0, 70000);
            default: return $urandom_range(51, 3000);
        endcase
    endfunction

    task automatic run_random_events(input int quota);
        int               counted;
        int               pick;
        int               b;
        int               active;
        logic             plev;
        logic [1:0]       lvl;
        logic [PIN_W-1:0] pin;
        logic [31:0]      t_rel;
        begin
            counted = 0;
            while (counted < quota) begin
                active = (model_cfg.count > NUM_SLOTS) ? NUM_SLOTS : model_cfg.count;
                pick = $urandom_range(0, 99);
                cur_tick += $urandom_range(0, 300000);
                b = (active > 0) ? $urandom_range(0, active - 1) : 0;
                pin = model_cfg.pins[PIN_W*b +: PIN_W];
                plev = model_cfg.levels[b];
                if (active > 0 && pick < 72) begin
                    t_rel = cur_tick + pick_hold(model_cfg.long_ms[b]) * 1000
                            + $urandom_range(0, 999);
                    send_event(pin, {1'b0, plev}, cur_tick);
                    if ($urandom_range(0, 9) == 0)
                        send_event(PIN_W'($urandom), 2'($urandom_range(0, 3)),
                                   cur_tick + $urandom_range(0, 100000));
                    send_event(pin, {1'b0, ~plev}, t_rel);
                    cur_tick = t_rel;
                    counted += 2;
                end else if (active > 0 && pick < 82) begin
                    send_event(pin, 2'($urandom_range(0, 1)), cur_tick);
                    counted++;
                end else begin
                    lvl = 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 1)) pin = PIN_W'($urandom);
                    send_event(pin, lvl, ($urandom_range(0, 3) == 0) ? $urandom : cur_tick);
                    if (lvl <= 2'd1) counted++;
                end
            end
        end
    endtask

    // Nothing is enabled after reset; then one button checks the reset threshold.
    task automatic test_reset_defaults();
        send_event(6'd0, 2'd1, 32'd2_000_000);
        send_event(6'd0, 2'd0, 32'd3_000_000);
        settle();
        config_write(REG_BUTTON_PINS, 32'd0);
        config_write(REG_BUTTON_COUNT, 32'd1);
        config_write(REG_PRESSED_LEVELS, 32'd1);
        send_event(6'd0, 2'd1, 32'd4_000_000);
        send_event(6'd0, 2'd0, 32'd5_000_000);
        send_event(6'd0, 2'd1, 32'd6_000_000);
        send_event(6'd0, 2'd0, 32'd7_001_000);
    endtask

    task automatic test_single_buttons();
        t_cfg c;
        begin
            c.pins = {6'd42, 6'd0, 6'd63, 6'd5};
            c.count = 3'd4;
            c.levels = 4'b0101;
            c.long_ms = {16'd50, 16'd1000, 16'hFFFF, 16'd0};
            settle();
            apply_config(c);
            // Levels two and three are dropped.
            send_event(6'd5, 2'd2, 32'd1_000_000);
            send_event(6'd5, 2'd3, 32'd1_000_000);
            send_event(6'd5, 2'd1, 32'd1_000_000);
            send_event(6'd5, 2'd0, 32'd1_049_999);
            send_event(6'd5, 2'd1, 32'd2_000_000);
            send_event(6'd5, 2'd0, 32'd2_050_000);
            send_event(6'd63, 2'd0, 32'd3_000_000);
            send_event(6'd63, 2'd1, 32'd68_535_000);
            send_event(6'd63, 2'd0, 32'd100_000_000);
            send_event(6'd63, 2'd1, 32'd165_536_000);
            // A press inside the first millisecond reads as not held.
            send_event(6'd0, 2'd1, 32'd999);
            send_event(6'd0, 2'd0, 32'd200_000);
            // Release before the press: wrapped elapsed time, then nothing held.
            send_event(6'd42, 2'd0, 32'd300_000_000);
            send_event(6'd42, 2'd1, 32'd250_000_000);
            send_event(6'd42, 2'd1, 32'd400_000_000);
            send_event(6'd42, 2'd0, 32'd10_000_000);
            send_event(6'd42, 2'd1, 32'd10_051_000);
            // A second pressed edge while held completes the press.
            send_event(6'd0, 2'd1, 32'd5_000_000);
            send_event(6'd0, 2'd1, 32'd5_300_000);
            send_event(6'd0, 2'd1, 32'd4_294_000_000);
            send_event(6'd0, 2'd0, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_shared_pin();
        t_cfg c;
        begin
            c.pins = {4{6'd17}};
            c.count = 3'd4;
            c.levels = 4'b0011;
            c.long_ms = {16'd400, 16'd300, 16'd200, 16'd100};
            settle();
            apply_config(c);
            send_event(6'd17, 2'd1, 32'd7_000_000);
            send_event(6'd17, 2'd0, 32'd7_250_000);
            send_event(6'd17, 2'd1, 32'd7_600_000);
            settle();
            config_write(REG_PRESSED_LEVELS, 32'd0);
            send_event(6'd17, 2'd1, 32'd8_000_000);
            send_event(6'd17, 2'd0, 32'd9_000_000);
            send_event(6'd17, 2'd1, 32'd9_150_000);
        end
    endtask

    // Count above four saturates; a write past the last register changes nothing.
    task automatic test_count_and_unused_register();
        t_cfg c;
        begin
            c.pins = {6'd4, 6'd3, 6'd2, 6'd1};
            c.count = 3'd7;
            c.levels = 4'b1111;
            c.long_ms = {4{16'd500}};
            settle();
            apply_config(c);
            config_write(REG_UNUSED, 32'd0);
            send_event(6'd4, 2'd1, 32'd20_000_000);
            send_event(6'd4, 2'd0, 32'd20_100_000);
            settle();
            config_write(REG_BUTTON_COUNT, 32'd2);
            send_event(6'd3, 2'd1, 32'd21_000_000);
            send_event(6'd3, 2'd0, 32'd21_100_000);
            send_event(6'd2, 2'd1, 32'd22_000_000);
            send_event(6'd2, 2'd0, 32'd22_600_000);
        end
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        begin
            cur_tick = $urandom;
            for (int phase = 0; phase < 8; phase++) begin
                if (phase == 0) begin
                    c.pins = '1;
                    c.count = 3'd4;
                    c.levels = '1;
                    c.long_ms = '1;
                end else if (phase == 7) begin
                    c.pins = '0;
                    c.count = 3'd7;
                    c.levels = '0;
                    c.long_ms = '0;
                end else begin
                    c = random_config();
                end
                settle();
                idle_mode = t_idle_mode'(phase % 4);
                apply_config(c);
                run_random_events(PHASE_ITEMS);
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_single_buttons();
        test_shared_pin();
        test_count_and_unused_register();
        test_random_traffic();
        settle();
        $display("summary: %0d pin edges sent, %0d press results checked, %0d mismatches",
                 events_sent, results_checked, mismatches);
        $display("summary: covered reset values, thresholds, wrap, shared pins, idle phases");
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_cfg.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_queue.sv
hw/rtl/bpc_back.sv
hw/rtl/button_press_classifier_core.sv
hw/rtl/bpc_checker.sv
test/testbench.sv
